[rtl/tjb_pkg.sv]
// Shared types, widths and codes for the timestamp join buffer.
package tjb_pkg;

  localparam int CMD_W       = 2;
  localparam int TS_W        = 64;
  localparam int TAG_W       = 32;
  localparam int OCC_W       = 5;
  localparam int MAXE_W      = 5;
  localparam int MASK_W      = 3;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (TS_W + 3 * TAG_W + OCC_W);

  localparam int SLOTS_DEF    = 16;
  localparam int TAG_BITS_DEF = 32;

  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 5'd16;
  localparam logic [MASK_W-1:0] MASK_ALL        = 3'b111;

  localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRACKER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PLANNER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_CHECK,
    S_MIN,
    S_EVICT,
    S_ALLOC,
    S_FLUSH,
    S_EMIT
  } tjb_state_t;

  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_min;
    logic update;
    logic evict;
    logic alloc;
    logic flush;
    logic out_load;
  } tjb_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic complete;
    logic over_limit;
    logic pending;
    logic best_pending;
    logic best_found;
  } tjb_stat_t;

endpackage

[rtl/timestamp_join_buffer.sv]
// Top level of the timestamp join buffer: three-source join by exact timestamp.
//
//  Channel | Direction | Payload
//  --------+-----------+---------------------------------------------------------------
//  in_     | slave     | tuser: command; tdata: timestamp, payload_tag
//  out_    | master    | tuser: complete; tdata: timestamp, frame, tracker, planner, occ
//  cfg_    | write     | wdata: max_entries
//
// One transaction at a time: an arrival passes accept, lookup scan, update, check, allocate
// and emit before the next acceptance; a completing arrival skips check and allocate, a
// repeated source skips allocate. Each eviction adds a scan, evict and check. Flush passes
// accept, flush and emit.
// Reset clears valid bits and occupancy and sets max_entries to 16; no clearing pass.
// Emit holds while the previous result waits in the output register.
module timestamp_join_buffer #(
  parameter int SLOTS    = tjb_pkg::SLOTS_DEF,
  parameter int TAG_BITS = tjb_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tjb_pkg::IN_TDATA_W-1:0]  in_tdata,   // timestamp[63:0], payload_tag[95:64]
  input  logic [tjb_pkg::CMD_W-1:0]       in_tuser,   // command[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tjb_pkg::OUT_TDATA_W-1:0] out_tdata,  // timestamp[63:0], frame_tag[95:64],
                                                      // tracker_tag[127:96],
                                                      // planner_tag[159:128],
                                                      // occupancy[164:160], zero pad
  output logic                            out_tuser,  // complete
  input  logic                            cfg_we,
  input  logic [tjb_pkg::MAXE_W-1:0]      cfg_wdata   // max_entries
);
  import tjb_pkg::*;

  tjb_cmd_t          cmd;
  tjb_stat_t         stat;
  logic              res_complete;
  logic [TS_W-1:0]   res_ts;
  logic [TAG_W-1:0]  res_frame;
  logic [TAG_W-1:0]  res_tracker;
  logic [TAG_W-1:0]  res_planner;
  logic [OCC_W-1:0]  res_occ;

  tjb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  tjb_dpath #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_tuser),
    .in_ts        (in_tdata[TS_W-1:0]),
    .in_tag       (in_tdata[TS_W +: TAG_W]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_complete (res_complete),
    .out_ts       (res_ts),
    .out_frame    (res_frame),
    .out_tracker  (res_tracker),
    .out_planner  (res_planner),
    .out_occ      (res_occ)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_occ, res_planner, res_tracker, res_frame, res_ts};
  assign out_tuser = res_complete;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("transaction accepted while busy");

  a_alloc_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> (stat.pending && !stat.over_limit))
    else $error("allocation without a surviving pending arrival");

  a_evict_target: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> (stat.best_pending || stat.best_found))
    else $error("eviction without a candidate");

  a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |=> !cmd.scan_start)
    else $error("scan restarted back to back");

endmodule

[rtl/tjb_ctrl.sv]
// Control state machine: sequences lookup, update, eviction, allocation, flush and output.
module tjb_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic [tjb_pkg::CMD_W-1:0] in_cmd,
  output logic                    in_tready,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  input  tjb_pkg::tjb_stat_t      stat,
  output tjb_pkg::tjb_cmd_t       cmd
);
  import tjb_pkg::*;

  tjb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_cmd == CMD_FLUSH) ? S_FLUSH : S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.scan_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = (stat.hit && stat.complete) ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        if (stat.over_limit) begin
          state_nxt = S_MIN;
        end else if (stat.pending) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MIN: begin
        if (stat.scan_done) begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: state_nxt = S_CHECK;
      S_ALLOC: state_nxt = S_EMIT;
      S_FLUSH: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch      = 1'b1;
          cmd.scan_start = (in_cmd != CMD_FLUSH);
        end
      end
      S_UPD: cmd.update = 1'b1;
      S_CHECK: begin
        if (stat.over_limit) begin
          cmd.scan_start = 1'b1;
          cmd.scan_min   = 1'b1;
        end
      end
      S_EVICT: cmd.evict = 1'b1;
      S_ALLOC: cmd.alloc = 1'b1;
      S_FLUSH: cmd.flush = 1'b1;
      S_EMIT:  cmd.out_load = !out_valid_r || out_tready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/tjb_dpath.sv]
// Datapath: slot memory, valid bits, scan engine, eviction tracking and output register.
module tjb_dpath #(
  parameter int SLOTS    = tjb_pkg::SLOTS_DEF,
  parameter int TAG_BITS = tjb_pkg::TAG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tjb_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tjb_pkg::TS_W-1:0]   in_ts,
  input  logic [tjb_pkg::TAG_W-1:0]  in_tag,
  input  logic                       cfg_we,
  input  logic [tjb_pkg::MAXE_W-1:0] cfg_wdata,
  input  tjb_pkg::tjb_cmd_t          cmd,
  output tjb_pkg::tjb_stat_t         stat,
  output logic                       out_complete,
  output logic [tjb_pkg::TS_W-1:0]   out_ts,
  output logic [tjb_pkg::TAG_W-1:0]  out_frame,
  output logic [tjb_pkg::TAG_W-1:0]  out_tracker,
  output logic [tjb_pkg::TAG_W-1:0]  out_planner,
  output logic [tjb_pkg::OCC_W-1:0]  out_occ
);
  import tjb_pkg::*;

  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int LIM_W      = ((CNT_W > MAXE_W) ? CNT_W : MAXE_W) + 1;
  localparam int MASK_LO    = TS_W;
  localparam int FRAME_LO   = TS_W + MASK_W;
  localparam int TRACKER_LO = FRAME_LO + TAG_BITS;
  localparam int PLANNER_LO = TRACKER_LO + TAG_BITS;
  localparam int REC_W      = PLANNER_LO + TAG_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [REC_W-1:0]    mem [SLOTS];
  logic [REC_W-1:0]    rd_rec_r;

  logic [CMD_W-1:0]    cmd_r;
  logic [TS_W-1:0]     ts_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [MAXE_W-1:0]   max_entries_r;
  logic [SLOTS-1:0]    valid_r;
  logic [CNT_W-1:0]    count_r;
  logic                pending_r;
  logic                comp_r;

  logic                scanning_r;
  logic                scan_min_r;
  logic [IDX_W-1:0]    addr_r;
  logic                chk_v_r;
  logic [IDX_W-1:0]    chk_idx_r;

  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [REC_W-1:0]    hit_rec_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic                best_pending_r;
  logic                best_found_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [TS_W-1:0]     best_time_r;

  logic [TAG_W+TAG_BITS-1:0] tag_in_ext;
  logic [MASK_W-1:0]         cmd_bit;
  logic [REC_W-1:0]          upd_rec;
  logic [REC_W-1:0]          new_rec;
  logic                      upd_all;
  logic [TS_W-1:0]           rd_time;
  logic                      chk_valid;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [REC_W-1:0]          mem_wdata;
  logic [LIM_W-1:0]          lim_cfg;
  logic [LIM_W-1:0]          lim_slots;
  logic [LIM_W-1:0]          limit;
  logic [LIM_W-1:0]          total;
  logic [OCC_W+CNT_W-1:0]    occ_ext;
  logic [TAG_BITS+TAG_W-1:0] frame_ext;
  logic [TAG_BITS+TAG_W-1:0] tracker_ext;
  logic [TAG_BITS+TAG_W-1:0] planner_ext;

  assign tag_in_ext = {{TAG_BITS{1'b0}}, in_tag};
  assign cmd_bit    = MASK_W'(1) << cmd_r;
  assign rd_time    = rd_rec_r[TS_W-1:0];
  assign chk_valid  = valid_r[chk_idx_r];

  always_comb begin
    upd_rec = hit_rec_r;
    upd_rec[MASK_LO +: MASK_W] = hit_rec_r[MASK_LO +: MASK_W] | cmd_bit;
    new_rec = '0;
    new_rec[TS_W-1:0]          = ts_r;
    new_rec[MASK_LO +: MASK_W] = cmd_bit;
    case (cmd_r)
      CMD_FRAME: begin
        upd_rec[FRAME_LO +: TAG_BITS] = tag_r;
        new_rec[FRAME_LO +: TAG_BITS] = tag_r;
      end
      CMD_TRACKER: begin
        upd_rec[TRACKER_LO +: TAG_BITS] = tag_r;
        new_rec[TRACKER_LO +: TAG_BITS] = tag_r;
      end
      CMD_PLANNER: begin
        upd_rec[PLANNER_LO +: TAG_BITS] = tag_r;
        new_rec[PLANNER_LO +: TAG_BITS] = tag_r;
      end
      default: begin
      end
    endcase
  end

  assign upd_all = (upd_rec[MASK_LO +: MASK_W] == MASK_ALL);

  assign lim_cfg   = LIM_W'(max_entries_r);
  assign lim_slots = LIM_W'(SLOTS);
  assign limit     = (lim_cfg < lim_slots) ? lim_cfg : lim_slots;
  assign total     = LIM_W'(count_r) + LIM_W'(pending_r);

  assign mem_we    = (cmd.update && hit_r) || cmd.alloc;
  assign mem_waddr = cmd.alloc ? free_idx_r : hit_idx_r;
  assign mem_wdata = cmd.alloc ? new_rec : upd_rec;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_rec_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      ts_r  <= in_ts;
      tag_r <= tag_in_ext[TAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
    end else if (cfg_we) begin
      max_entries_r <= cfg_wdata;
    end
  end

  // scan engine: issue one address per cycle, check the returned entry in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      chk_v_r    <= 1'b0;
      scan_min_r <= 1'b0;
      addr_r     <= '0;
      chk_idx_r  <= '0;
    end else begin
      chk_v_r   <= scanning_r;
      chk_idx_r <= addr_r;
      if (cmd.scan_start) begin
        scanning_r <= 1'b1;
        scan_min_r <= cmd.scan_min;
        addr_r     <= '0;
      end else if (scanning_r) begin
        if (addr_r == LAST_IDX) begin
          scanning_r <= 1'b0;
        end else begin
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r          <= 1'b0;
      best_pending_r <= 1'b0;
      best_found_r   <= 1'b0;
      free_idx_r     <= '0;
    end else begin
      if (cmd.scan_start && !cmd.scan_min) begin
        hit_r <= 1'b0;
      end else if (cmd.scan_start) begin
        best_pending_r <= pending_r;
        best_found_r   <= 1'b0;
        best_time_r    <= ts_r;
      end else if (chk_v_r && !scan_min_r) begin
        if (chk_valid && (rd_time == ts_r)) begin
          hit_r     <= 1'b1;
          hit_idx_r <= chk_idx_r;
          hit_rec_r <= rd_rec_r;
        end
        if (!chk_valid) begin
          free_idx_r <= chk_idx_r;
        end
      end else if (chk_v_r) begin
        if (chk_valid && ((!best_pending_r && !best_found_r) ||
                          ($signed(rd_time) < $signed(best_time_r)))) begin
          best_found_r   <= 1'b1;
          best_pending_r <= 1'b0;
          best_idx_r     <= chk_idx_r;
          best_time_r    <= rd_time;
        end
      end
      if (cmd.update && hit_r) begin
        hit_rec_r <= upd_rec;
      end
      if (cmd.evict && !best_pending_r && best_found_r) begin
        free_idx_r <= best_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      pending_r <= 1'b0;
      comp_r    <= 1'b0;
    end else begin
      if (cmd.latch) begin
        pending_r <= 1'b0;
        comp_r    <= 1'b0;
      end
      if (cmd.flush) begin
        valid_r <= '0;
        count_r <= '0;
      end
      if (cmd.update) begin
        if (!hit_r) begin
          pending_r <= 1'b1;
        end else if (upd_all) begin
          comp_r             <= 1'b1;
          valid_r[hit_idx_r] <= 1'b0;
          count_r            <= count_r - 1'b1;
        end
      end
      if (cmd.evict) begin
        if (best_pending_r) begin
          pending_r <= 1'b0;
        end else if (best_found_r) begin
          valid_r[best_idx_r] <= 1'b0;
          count_r             <= count_r - 1'b1;
        end
      end
      if (cmd.alloc) begin
        valid_r[free_idx_r] <= 1'b1;
        count_r             <= count_r + 1'b1;
        pending_r           <= 1'b0;
      end
    end
  end

  assign occ_ext     = {{OCC_W{1'b0}}, count_r};
  assign frame_ext   = {{TAG_W{1'b0}}, hit_rec_r[FRAME_LO +: TAG_BITS]};
  assign tracker_ext = {{TAG_W{1'b0}}, hit_rec_r[TRACKER_LO +: TAG_BITS]};
  assign planner_ext = {{TAG_W{1'b0}}, hit_rec_r[PLANNER_LO +: TAG_BITS]};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_complete <= comp_r;
      out_ts       <= comp_r ? hit_rec_r[TS_W-1:0] : '0;
      out_frame    <= comp_r ? frame_ext[TAG_W-1:0] : '0;
      out_tracker  <= comp_r ? tracker_ext[TAG_W-1:0] : '0;
      out_planner  <= comp_r ? planner_ext[TAG_W-1:0] : '0;
      out_occ      <= occ_ext[OCC_W-1:0];
    end
  end

  always_comb begin
    stat              = '0;
    stat.scan_done    = chk_v_r && (chk_idx_r == LAST_IDX);
    stat.hit          = hit_r;
    stat.complete     = upd_all;
    stat.over_limit   = (total > limit);
    stat.pending      = pending_r;
    stat.best_pending = best_pending_r;
    stat.best_found   = best_found_r;
  end

endmodule
